[rtl/assert_macros.svh]
// ---------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, compiled out with NO_ASSERTIONS
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// expression must never hold outside reset
`define ASSERT_NEVER(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("assertion failed: label");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: label");

`else

`define ASSERT_NEVER(label, clk, rst_n, expr)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

[rtl/prc_pkg.sv]
// ---------------------------------------------------------------------------
// prc_pkg
// shared types, constants and the crc-32 byte update for the packet checker
// ---------------------------------------------------------------------------
`default_nettype none

package prc_pkg;

  localparam int unsigned HEADER_BYTES = 16;
  localparam int unsigned POS_W        = 17;
  localparam int unsigned CFG_IDX_W    = 8;
  localparam int unsigned CFG_DATA_W   = 16;
  localparam int unsigned QUEUE_DEPTH  = 2;

  localparam logic [POS_W-1:0] POS_MAX      = {POS_W{1'b1}};
  localparam logic [31:0]      CRC_POLY     = 32'hEDB88320;
  localparam logic [31:0]      CRC_ALL_ONES = 32'hFFFFFFFF;

  localparam logic [7:0]  VERSION_RESET = 8'd1;
  localparam logic [15:0] MAX_LEN_RESET = 16'd1024;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_VERSION = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_MAX_LEN = 8'd1;

  // verdict codes
  localparam logic [2:0] VERDICT_OK        = 3'd0;
  localparam logic [2:0] VERDICT_SHORT     = 3'd1;
  localparam logic [2:0] VERDICT_VERSION   = 3'd2;
  localparam logic [2:0] VERDICT_TOO_LONG  = 3'd3;
  localparam logic [2:0] VERDICT_TRUNCATED = 3'd4;
  localparam logic [2:0] VERDICT_CRC       = 3'd5;

  // result kinds
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  // byte class assigned by the front end
  typedef enum logic [2:0] {
    CLS_VERSION = 3'd0,
    CLS_TYPE    = 3'd1,
    CLS_SEQ     = 3'd2,
    CLS_TOTAL   = 3'd3,
    CLS_LENGTH  = 3'd4,
    CLS_CHECK   = 3'd5,
    CLS_PAYLOAD = 3'd6,
    CLS_SKIP    = 3'd7
  } cls_t;

  // one classified item in the queue
  typedef struct packed {
    logic [7:0] data;
    cls_t       cls;
    logic       last;
    logic       short_pkt;
    logic       truncated;
  } q_entry_t;

  // reflected crc-32, one byte
  function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
    logic [31:0] c;
    c = c_in ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

[rtl/packet_receive_checker_unit.sv]
// ---------------------------------------------------------------------------
// packet_receive_checker_unit
// byte-stream receiver: parses the 16-byte header, passes payload through,
// checks the crc-32 and reports one verdict per datagram
// ---------------------------------------------------------------------------
//
//  channel   direction  handshake           payload
//  --------  ---------  ------------------  -------------------------------------
//  in        sink       in_valid/in_stall   in_rx_byte, in_last_byte
//  out       source     out_valid/out_stall out_kind, out_payload_data, verdict,
//                                           header fields
//  cfg       sink       cfg_wr_en           cfg_index, cfg_wdata
//
//  one item per cycle sustained while no waiting result is stalled; the
//  byte-wide crc update in the back end sets the cycle time
//  an accepted item passes through the queue, then the result register
//  in_stall rises only when the two-entry queue is full; in a steady stream
//  that happens once a waiting result is stalled
//  synchronous active-low reset restores configuration and packet-state
//  defaults, clears out_valid and empties the queue; no clearing pass is needed
// ---------------------------------------------------------------------------
`default_nettype none

module packet_receive_checker_unit (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // configuration
  input  wire logic                           cfg_wr_en,
  input  wire logic [prc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [prc_pkg::CFG_DATA_W-1:0] cfg_wdata,
  // input bytes
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [7:0]                     in_rx_byte,
  input  wire logic                           in_last_byte,
  // results
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic                                out_kind,
  output logic [7:0]                          out_payload_data,
  output logic [2:0]                          out_verdict,
  output logic [7:0]                          out_packet_kind,
  output logic [31:0]                         out_sequence_number,
  output logic [31:0]                         out_chunk_total,
  output logic [15:0]                         out_body_length
);
  import prc_pkg::*;

  logic     take;       // item accepted this cycle
  logic     q_full;
  logic     q_valid;
  logic     q_pop;
  q_entry_t front_entry;
  q_entry_t q_head;

  // stall only on a full queue, never on in_valid
  assign in_stall = q_full;
  assign take     = in_valid && !q_full;

  // front end: position counter, declared length, byte class
  prc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .rx_byte   (in_rx_byte),
    .last_byte (in_last_byte),
    .entry     (front_entry)
  );

  // decoupling queue
  prc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (take),
    .push_entry (front_entry),
    .full       (q_full),
    .not_empty  (q_valid),
    .pop        (q_pop),
    .head       (q_head)
  );

  // back end: header capture, crc, verdict, result register
  prc_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .q_valid             (q_valid),
    .q_head              (q_head),
    .q_pop               (q_pop),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_kind            (out_kind),
    .out_payload_data    (out_payload_data),
    .out_verdict         (out_verdict),
    .out_packet_kind     (out_packet_kind),
    .out_sequence_number (out_sequence_number),
    .out_chunk_total     (out_chunk_total),
    .out_body_length     (out_body_length)
  );

endmodule

`default_nettype wire

[rtl/prc_front.sv]
// ---------------------------------------------------------------------------
// prc_front
// tracks byte position and declared length, classifies each item
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module prc_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              take,
  input  wire logic [7:0]        rx_byte,
  input  wire logic              last_byte,
  output prc_pkg::q_entry_t      entry
);
  import prc_pkg::*;

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [15:0]      len_r, len_nxt;
  cls_t             cls;
  logic [POS_W:0]   trunc_bound;

  always_comb begin
    if (pos_r == POS_W'(0))                 cls = CLS_VERSION;
    else if (pos_r == POS_W'(1))            cls = CLS_TYPE;
    else if (pos_r < POS_W'(6))             cls = CLS_SEQ;
    else if (pos_r < POS_W'(10))            cls = CLS_TOTAL;
    else if (pos_r < POS_W'(12))            cls = CLS_LENGTH;
    else if (pos_r < POS_W'(HEADER_BYTES))  cls = CLS_CHECK;
    else if ((pos_r - POS_W'(HEADER_BYTES)) < {1'b0, len_r}) cls = CLS_PAYLOAD;
    else                                    cls = CLS_SKIP;
  end

  always_comb begin
    len_nxt = (cls == CLS_LENGTH) ? {len_r[7:0], rx_byte} : len_r;
  end

  // n < header + len, with n = pos + 1
  assign trunc_bound = (POS_W+1)'(HEADER_BYTES - 1) + {2'b00, len_nxt};

  always_comb begin
    entry.data      = rx_byte;
    entry.cls       = cls;
    entry.last      = last_byte;
    entry.short_pkt = pos_r < POS_W'(HEADER_BYTES - 1);
    entry.truncated = {1'b0, pos_r} < trunc_bound;
  end

  always_comb begin
    pos_nxt = pos_r;
    if (take) begin
      if (last_byte)            pos_nxt = '0;
      else if (pos_r != POS_MAX) pos_nxt = pos_r + POS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      len_r <= '0;
    end else if (take) begin
      pos_r <= pos_nxt;
      len_r <= last_byte ? 16'd0 : len_nxt;
    end
  end

  // position only moves up by one, holds at max, or restarts
  `ASSERT_NEVER(a_pos_step, clk, rst_n,
    take && !last_byte && (pos_nxt != pos_r + POS_W'(1)) && (pos_r != POS_MAX))

endmodule

`default_nettype wire

[rtl/prc_queue.sv]
// ---------------------------------------------------------------------------
// prc_queue
// two-entry queue of classified items between front and back
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module prc_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire prc_pkg::q_entry_t push_entry,
  output logic                   full,
  output logic                   not_empty,
  input  wire logic              pop,
  output prc_pkg::q_entry_t      head
);
  import prc_pkg::*;

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  q_entry_t         slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full      = count_r == CNT_W'(QUEUE_DEPTH);
  assign not_empty = count_r != CNT_W'(0);
  assign head      = slot_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop)      count_nxt = count_r + CNT_W'(1);
    else if (!push && pop) count_nxt = count_r - CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      if (pop)  rd_ptr_r <= (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      count_r <= count_nxt;
    end
  end

  `ASSERT_NEVER(a_q_overflow, clk, rst_n, push && full && !pop)
  `ASSERT_NEVER(a_q_underflow, clk, rst_n, pop && !not_empty)

endmodule

`default_nettype wire

[rtl/prc_back.sv]
// ---------------------------------------------------------------------------
// prc_back
// header capture, crc update, verdict and the registered result stage
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module prc_back (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_wr_en,
  input  wire logic [prc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [prc_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                           q_valid,
  input  wire prc_pkg::q_entry_t              q_head,
  output logic                                q_pop,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic                                out_kind,
  output logic [7:0]                          out_payload_data,
  output logic [2:0]                          out_verdict,
  output logic [7:0]                          out_packet_kind,
  output logic [31:0]                         out_sequence_number,
  output logic [31:0]                         out_chunk_total,
  output logic [15:0]                         out_body_length
);
  import prc_pkg::*;

  logic [7:0]  exp_ver_r;
  logic [15:0] max_len_r;

  logic [31:0] crc_r, crc_nxt;
  logic [7:0]  ver_r, ver_nxt;
  logic [7:0]  type_r, type_nxt;
  logic [31:0] seq_r, seq_nxt;
  logic [31:0] total_r, total_nxt;
  logic [15:0] len_r, len_nxt;
  logic [31:0] chk_r, chk_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic        kind_r;
  logic [7:0]  data_r;
  logic [2:0]  verdict_r, verdict_nxt;
  logic [7:0]  pkind_r;
  logic [31:0] seqo_r, totalo_r;
  logic [15:0] leno_r;

  logic        produce;
  logic [7:0]  b;

  assign b       = q_head.data;
  assign q_pop   = q_valid && (!out_valid_r || !out_stall);
  assign produce = q_head.last || (q_head.cls == CLS_PAYLOAD);

  always_comb begin
    ver_nxt   = (q_head.cls == CLS_VERSION) ? b : ver_r;
    type_nxt  = (q_head.cls == CLS_TYPE)    ? b : type_r;
    seq_nxt   = (q_head.cls == CLS_SEQ)     ? {seq_r[23:0], b}   : seq_r;
    total_nxt = (q_head.cls == CLS_TOTAL)   ? {total_r[23:0], b} : total_r;
    len_nxt   = (q_head.cls == CLS_LENGTH)  ? {len_r[7:0], b}    : len_r;
    chk_nxt   = (q_head.cls == CLS_CHECK)   ? {chk_r[23:0], b}   : chk_r;
    // check bytes and trailing bytes stay out of the crc
    if (q_head.cls == CLS_CHECK || q_head.cls == CLS_SKIP) crc_nxt = crc_r;
    else                                                   crc_nxt = crc_byte(crc_r, b);
  end

  always_comb begin
    if (q_head.short_pkt)                        verdict_nxt = VERDICT_SHORT;
    else if (ver_nxt != exp_ver_r)               verdict_nxt = VERDICT_VERSION;
    else if (len_nxt > max_len_r)                verdict_nxt = VERDICT_TOO_LONG;
    else if (q_head.truncated)                   verdict_nxt = VERDICT_TRUNCATED;
    else if ((crc_nxt ^ CRC_ALL_ONES) != chk_nxt) verdict_nxt = VERDICT_CRC;
    else                                         verdict_nxt = VERDICT_OK;
  end

  assign out_valid_nxt = q_pop ? produce : (out_valid_r && out_stall);

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_ver_r <= VERSION_RESET;
      max_len_r <= MAX_LEN_RESET;
    end else if (cfg_wr_en) begin
      if (cfg_index == CFG_IDX_VERSION)      exp_ver_r <= cfg_wdata[7:0];
      else if (cfg_index == CFG_IDX_MAX_LEN) max_len_r <= cfg_wdata;
    end
  end

  // per-packet state, cleared after every verdict
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r   <= CRC_ALL_ONES;
      ver_r   <= '0;
      type_r  <= '0;
      seq_r   <= '0;
      total_r <= '0;
      len_r   <= '0;
      chk_r   <= '0;
    end else if (q_pop) begin
      if (q_head.last) begin
        crc_r   <= CRC_ALL_ONES;
        ver_r   <= '0;
        type_r  <= '0;
        seq_r   <= '0;
        total_r <= '0;
        len_r   <= '0;
        chk_r   <= '0;
      end else begin
        crc_r   <= crc_nxt;
        ver_r   <= ver_nxt;
        type_r  <= type_nxt;
        seq_r   <= seq_nxt;
        total_r <= total_nxt;
        len_r   <= len_nxt;
        chk_r   <= chk_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= out_valid_nxt;
  end

  // result payload
  always_ff @(posedge clk) begin
    if (q_pop && produce) begin
      if (q_head.last) begin
        kind_r    <= KIND_VERDICT;
        data_r    <= '0;
        verdict_r <= verdict_nxt;
        pkind_r   <= type_nxt;
        seqo_r    <= seq_nxt;
        totalo_r  <= total_nxt;
        leno_r    <= len_nxt;
      end else begin
        kind_r    <= KIND_PAYLOAD;
        data_r    <= b;
        verdict_r <= VERDICT_OK;
        pkind_r   <= '0;
        seqo_r    <= '0;
        totalo_r  <= '0;
        leno_r    <= '0;
      end
    end
  end

  assign out_valid           = out_valid_r;
  assign out_kind            = kind_r;
  assign out_payload_data    = data_r;
  assign out_verdict         = verdict_r;
  assign out_packet_kind     = pkind_r;
  assign out_sequence_number = seqo_r;
  assign out_chunk_total     = totalo_r;
  assign out_body_length     = leno_r;

  // a payload result never carries a verdict code
  `ASSERT_NEVER(a_payload_clean, clk, rst_n,
    out_valid_r && (kind_r == KIND_PAYLOAD) && (verdict_r != VERDICT_OK))
  // a verdict always restarts the crc
  `ASSERT_NEXT(a_crc_restart, clk, rst_n, q_pop && q_head.last, crc_r == CRC_ALL_ONES)

endmodule

`default_nettype wire
